>>> hw/rtl/clsr_pkg.sv
// ----------------------------------------------------------------------------
// clsr_pkg
// Shared types and constants of the character display refresh block.
// ----------------------------------------------------------------------------
package clsr_pkg;

    localparam int ROWS_DEFAULT = 2;
    localparam int COLS_DEFAULT = 16;
    localparam int ROW_W        = 2;
    localparam int CHAR_W       = 8;
    localparam int MAX_ADDR_W   = 7;

    localparam logic [7:0] CMD_BASE    = 8'h80;
    localparam logic [7:0] LINE_STRIDE = 8'd40;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_DASH     = 8'h2D;

    typedef enum logic [2:0] {
        OP_PUT     = 3'd0,
        OP_REFRESH = 3'd1,
        OP_GOTO    = 3'd2,
        OP_FILL    = 3'd3,
        OP_HOME    = 3'd4
    } t_opcode;

    typedef struct packed {
        logic [MAX_ADDR_W-1:0] rd_addr;
        logic                  txt_we;
        logic [MAX_ADDR_W-1:0] txt_addr;
        logic [CHAR_W-1:0]     txt_data;
        logic                  shw_we;
        logic [MAX_ADDR_W-1:0] shw_addr;
        logic [CHAR_W-1:0]     shw_data;
        logic                  fill_we;
        logic [CHAR_W-1:0]     fill_data;
    } t_cell_req;

endpackage

>>> hw/rtl/clsr_cell_store.sv
// ----------------------------------------------------------------------------
// clsr_cell_store
// Text buffer and shown-copy memories with per-cell valid bits for the text.
// ----------------------------------------------------------------------------
module clsr_cell_store #(
    parameter int DEPTH = clsr_pkg::ROWS_DEFAULT * clsr_pkg::COLS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  clsr_pkg::t_cell_req         i_req,
    output logic [clsr_pkg::CHAR_W-1:0] o_cell,
    output logic [clsr_pkg::CHAR_W-1:0] o_shown
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [clsr_pkg::CHAR_W-1:0] txt_mem [DEPTH];
    logic [clsr_pkg::CHAR_W-1:0] shw_mem [DEPTH];
    logic [DEPTH-1:0]            r_valid;
    logic [clsr_pkg::CHAR_W-1:0] r_fill;
    logic [clsr_pkg::CHAR_W-1:0] r_txt_q;
    logic [clsr_pkg::CHAR_W-1:0] r_shw_q;
    logic                        r_vld_q;

    always_ff @(posedge i_clk) begin
        if (i_req.txt_we) begin
            txt_mem[i_req.txt_addr[AW-1:0]] <= i_req.txt_data;
        end
        if (i_req.shw_we) begin
            shw_mem[i_req.shw_addr[AW-1:0]] <= i_req.shw_data;
        end
        r_txt_q <= txt_mem[i_req.rd_addr[AW-1:0]];
        r_shw_q <= shw_mem[i_req.rd_addr[AW-1:0]];
        r_vld_q <= r_valid[i_req.rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= clsr_pkg::CH_DASH;
        end else if (i_req.fill_we) begin
            r_valid <= '0;
            r_fill  <= i_req.fill_data;
        end else if (i_req.txt_we) begin
            r_valid[i_req.txt_addr[AW-1:0]] <= 1'b1;
        end
    end

    assign o_cell  = r_vld_q ? r_txt_q : r_fill;
    assign o_shown = r_shw_q;

endmodule

>>> hw/rtl/char_lcd_shadow_refresh.sv
// ----------------------------------------------------------------------------
// char_lcd_shadow_refresh
// Character display text buffer with cursor and shadow-copy refresh.
// ----------------------------------------------------------------------------
// Put char, goto, fill and home complete in idle.
// A refresh walks every cell through the memory read port (read, compare,
// advance); each cell sent also passes the command and data states, which
// wait on a stalled output. No new item is taken until the walk ends.
// The last byte of a run is held back one cell to mark it with tlast.
// Synchronous active-low reset sets the cursor home, all text to dash.
module char_lcd_shadow_refresh #(
    parameter int ROWS = clsr_pkg::ROWS_DEFAULT,
    parameter int COLS = clsr_pkg::COLS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode[2:0], char_code[10:3], col[16:11], row[18:17]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic [0:0]  m_tuser,   // is_command[0]
    output logic        m_tlast,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int DEPTH   = ROWS * COLS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = $clog2(COLS + 1);
    localparam int RW      = clsr_pkg::ROW_W;
    localparam int HAS_TAB = ((COLS / 2) >= 1) ? 1 : 0;
    localparam int TAB_COL = (HAS_TAB != 0) ? (COLS / 2 - 1) : 0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_ADV,
        S_OCMD,
        S_ODAT
    } t_state;

    t_state      r_state, n_state;
    logic [CW-1:0] r_cur_col, n_cur_col;
    logic [RW-1:0] r_cur_row, n_cur_row;
    logic [7:0]  r_cd, n_cd;
    logic [7:0]  r_period;
    logic        r_full, n_full;
    logic [AW-1:0] r_scan_addr, n_scan_addr;
    logic [RW-1:0] r_scan_row, n_scan_row;
    logic [CW-1:0] r_scan_col, n_scan_col;
    logic        r_hold_vld, n_hold_vld;
    logic [7:0]  r_hold_cmd, n_hold_cmd;
    logic [7:0]  r_hold_dat, n_hold_dat;
    logic [7:0]  r_em_cmd, n_em_cmd;
    logic [7:0]  r_em_dat, n_em_dat;
    logic        r_em_last, n_em_last;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_cmd, n_out_cmd;
    logic        r_out_last, n_out_last;

    clsr_pkg::t_cell_req req;
    logic [7:0]          cell_q;
    logic [7:0]          shown;

    clsr_pkg::t_opcode in_op;
    logic [7:0]        in_char;
    logic [5:0]        in_col;
    logic [1:0]        in_row;
    logic              accept;
    logic              out_free;
    logic              cur_ok;
    logic [AW-1:0]     cur_addr;
    logic [7:0]        cd_dec;
    logic [7:0]        scan_cmd;

    assign in_op   = clsr_pkg::t_opcode'(s_tdata[2:0]);
    assign in_char = s_tdata[10:3];
    assign in_col  = s_tdata[16:11];
    assign in_row  = s_tdata[18:17];

    assign s_tready = (r_state == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !r_out_valid || m_tready;
    assign cur_ok   = (r_cur_col < CW'(COLS)) && (r_cur_row < RW'(ROWS));
    assign cur_addr = AW'(AW'(r_cur_row) * AW'(COLS)) + AW'(r_cur_col);
    assign cd_dec   = (r_cd != 8'd0) ? (r_cd - 8'd1) : 8'd0;
    assign scan_cmd = clsr_pkg::CMD_BASE + 8'(r_scan_row) * clsr_pkg::LINE_STRIDE
                      + 8'(r_scan_col);

    clsr_cell_store #(
        .DEPTH (DEPTH)
    ) u_cell_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_cell  (cell_q),
        .o_shown (shown)
    );

    always_comb begin
        n_state     = r_state;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_cd        = r_cd;
        n_full      = r_full;
        n_scan_addr = r_scan_addr;
        n_scan_row  = r_scan_row;
        n_scan_col  = r_scan_col;
        n_hold_vld  = r_hold_vld;
        n_hold_cmd  = r_hold_cmd;
        n_hold_dat  = r_hold_dat;
        n_em_cmd    = r_em_cmd;
        n_em_dat    = r_em_dat;
        n_em_last   = r_em_last;
        n_out_valid = r_out_valid && !m_tready;
        n_out_byte  = r_out_byte;
        n_out_cmd   = r_out_cmd;
        n_out_last  = r_out_last;

        req           = '0;
        req.rd_addr   = clsr_pkg::MAX_ADDR_W'(r_scan_addr);
        req.txt_addr  = clsr_pkg::MAX_ADDR_W'(cur_addr);
        req.txt_data  = in_char;
        req.shw_addr  = clsr_pkg::MAX_ADDR_W'(r_scan_addr);
        req.shw_data  = cell_q;
        req.fill_data = in_char;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (in_op)
                        clsr_pkg::OP_PUT: begin
                            if (cur_ok) begin
                                if (in_char == clsr_pkg::CH_NEWLINE) begin
                                    n_cur_row = r_cur_row + RW'(1);
                                    if ((r_cur_row + RW'(1)) < RW'(ROWS)) begin
                                        n_cur_col = '0;
                                    end
                                end else if (in_char == clsr_pkg::CH_TAB) begin
                                    if (HAS_TAB != 0) begin
                                        n_cur_col = CW'(TAB_COL);
                                    end
                                end else begin
                                    req.txt_we = 1'b1;
                                    n_cur_col  = r_cur_col + CW'(1);
                                end
                            end
                        end
                        clsr_pkg::OP_REFRESH: begin
                            n_full      = (cd_dec == 8'd0);
                            n_cd        = (cd_dec == 8'd0) ? r_period : cd_dec;
                            n_scan_addr = '0;
                            n_scan_row  = '0;
                            n_scan_col  = '0;
                            n_hold_vld  = 1'b0;
                            n_state     = S_RD;
                        end
                        clsr_pkg::OP_GOTO: begin
                            if ((in_col < 6'(COLS)) && (in_row < RW'(ROWS))) begin
                                n_cur_col = CW'(in_col);
                                n_cur_row = in_row;
                            end
                        end
                        clsr_pkg::OP_FILL: begin
                            req.fill_we = 1'b1;
                        end
                        clsr_pkg::OP_HOME: begin
                            n_cur_col = '0;
                            n_cur_row = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_ADV;
                if (r_full || (shown != cell_q)) begin
                    req.shw_we = 1'b1;
                    n_hold_vld = 1'b1;
                    n_hold_cmd = scan_cmd;
                    n_hold_dat = cell_q;
                    if (r_hold_vld) begin
                        n_em_cmd  = r_hold_cmd;
                        n_em_dat  = r_hold_dat;
                        n_em_last = 1'b0;
                        n_state   = S_OCMD;
                    end
                end
            end
            S_ADV: begin
                if (r_scan_addr == AW'(DEPTH - 1)) begin
                    if (r_hold_vld) begin
                        n_em_cmd   = r_hold_cmd;
                        n_em_dat   = r_hold_dat;
                        n_em_last  = 1'b1;
                        n_hold_vld = 1'b0;
                        n_state    = S_OCMD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_scan_addr = r_scan_addr + AW'(1);
                    if (r_scan_col == CW'(COLS - 1)) begin
                        n_scan_col = '0;
                        n_scan_row = r_scan_row + RW'(1);
                    end else begin
                        n_scan_col = r_scan_col + CW'(1);
                    end
                    n_state = S_RD;
                end
            end
            S_OCMD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_em_cmd;
                    n_out_cmd   = 1'b1;
                    n_out_last  = 1'b0;
                    n_state     = S_ODAT;
                end
            end
            S_ODAT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_em_dat;
                    n_out_cmd   = 1'b0;
                    n_out_last  = r_em_last;
                    n_state     = r_em_last ? S_IDLE : S_ADV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_cd        <= '0;
            r_period    <= '0;
            r_full      <= 1'b0;
            r_hold_vld  <= 1'b0;
            r_em_last   <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_cmd   <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_cd        <= n_cd;
            r_full      <= n_full;
            r_hold_vld  <= n_hold_vld;
            r_em_last   <= n_em_last;
            r_out_valid <= n_out_valid;
            r_out_cmd   <= n_out_cmd;
            r_out_last  <= n_out_last;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
        end
        r_scan_addr <= n_scan_addr;
        r_scan_row  <= n_scan_row;
        r_scan_col  <= n_scan_col;
        r_hold_cmd  <= n_hold_cmd;
        r_hold_dat  <= n_hold_dat;
        r_em_cmd    <= n_em_cmd;
        r_em_dat    <= n_em_dat;
        r_out_byte  <= n_out_byte;
    end

    assign m_tvalid   = r_out_valid;
    assign m_tdata    = r_out_byte;
    assign m_tuser[0] = r_out_cmd;
    assign m_tlast    = r_out_last;

endmodule

>>> hw/rtl/clsr_checker.sv
// ----------------------------------------------------------------------------
// clsr_checker
// Port-level checks of the refresh byte stream, bound to the top level.
// ----------------------------------------------------------------------------
module clsr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tuser) && $stable(m_tlast)))
        else $error("output item changed while stalled");

    a_cmd_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> !m_tlast)
        else $error("command byte marked as last of run");

    a_cmd_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tready && m_tuser[0]) |=> (m_tvalid && !m_tuser[0]))
        else $error("command byte not followed by its data byte");

    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> ((m_tdata[7:6] == 2'b10) || (m_tdata[7:4] == 4'hC)))
        else $error("address command byte out of range");

endmodule

bind char_lcd_shadow_refresh clsr_checker u_clsr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> sim/lcd_refresh_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_refresh_checker
// Watches both streams of the character display refresh block, keeps its own
// copy of the text buffer, cursor, shown copy and refresh countdown, predicts
// the command and data bytes of every refresh and compares each byte sent.
// ----------------------------------------------------------------------------
module lcd_refresh_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // opcode[2:0], char_code[10:3], col[16:11], row[18:17]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // out_byte[7:0]
    input  logic [0:0]  i_m_tuser,   // is_command[0]
    input  logic        i_m_tlast,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    output int          o_errors,
    output int          o_pending
);

    localparam int ROWS = clsr_pkg::ROWS_DEFAULT;
    localparam int COLS = clsr_pkg::COLS_DEFAULT;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_command;
        logic       last;
    } t_panel_byte;

    t_panel_byte bytes_due[$];
    logic [7:0]  text_cells  [ROWS][COLS];
    logic [7:0]  shown_cells [ROWS][COLS];
    logic [4:0]  cur_col;
    logic [1:0]  cur_row;
    logic [7:0]  refresh_count;
    logic [7:0]  full_period;
    int          err_count = 0;

    function automatic void fill_text(logic [7:0] ch);
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                text_cells[r][c] = ch;
            end
        end
    endfunction

    function automatic void place_cursor(int c, int r);
        if (c < COLS && r < ROWS) begin
            cur_col = 5'(c);
            cur_row = 2'(r);
        end
    endfunction

    function automatic void put_char(logic [7:0] ch);
        if (cur_col >= COLS || cur_row >= ROWS) begin
            return;
        end
        if (ch == clsr_pkg::CH_NEWLINE) begin
            // The row moves even when it leaves the panel; the column then stays.
            cur_row = cur_row + 2'd1;
            place_cursor(0, int'(cur_row));
        end else if (ch == clsr_pkg::CH_TAB) begin
            if (COLS / 2 >= 1) begin
                place_cursor(COLS / 2 - 1, int'(cur_row));
            end
        end else begin
            text_cells[cur_row][cur_col] = ch;
            cur_col = cur_col + 5'd1;
        end
    endfunction

    function automatic void refresh_panel();
        logic full_update;
        int   n_before;
        if (refresh_count != 8'd0) begin
            refresh_count = refresh_count - 8'd1;
        end
        full_update = (refresh_count == 8'd0);
        if (full_update) begin
            refresh_count = full_period;
        end
        n_before = bytes_due.size();
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                if (!full_update && shown_cells[r][c] == text_cells[r][c]) begin
                    continue;
                end
                shown_cells[r][c] = text_cells[r][c];
                bytes_due.push_back('{8'(int'(clsr_pkg::CMD_BASE)
                                         + r * int'(clsr_pkg::LINE_STRIDE) + c),
                                      1'b1, 1'b0});
                bytes_due.push_back('{text_cells[r][c], 1'b0, 1'b0});
            end
        end
        if (bytes_due.size() > n_before) begin
            bytes_due[bytes_due.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void apply_item(logic [23:0] d);
        logic [2:0] opc;
        logic [7:0] ch;
        logic [5:0] col;
        logic [1:0] row;
        opc = d[2:0];
        ch  = d[10:3];
        col = d[16:11];
        row = d[18:17];
        case (opc)
            clsr_pkg::OP_PUT:     put_char(ch);
            clsr_pkg::OP_REFRESH: refresh_panel();
            clsr_pkg::OP_GOTO:    place_cursor(int'(col), int'(row));
            clsr_pkg::OP_FILL:    fill_text(ch);
            clsr_pkg::OP_HOME: begin
                cur_col = 5'd0;
                cur_row = 2'd0;
            end
            default: ;
        endcase
    endfunction

    function automatic void check_byte(logic [7:0] b, logic cmd, logic lst);
        t_panel_byte want;
        if (bytes_due.size() == 0) begin
            $display("%0t: byte with nothing expected: actual %02h cmd %0b last %0b",
                     $time, b, cmd, lst);
            err_count++;
            return;
        end
        want = bytes_due.pop_front();
        if (b !== want.out_byte) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte, b);
            err_count++;
        end
        if (cmd !== want.is_command) begin
            $display("%0t: is_command expected %0b actual %0b", $time, want.is_command, cmd);
            err_count++;
        end
        if (lst !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, lst);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_text(clsr_pkg::CH_DASH);
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    shown_cells[r][c] = 8'h00;
                end
            end
            cur_col       = 5'd0;
            cur_row       = 2'd0;
            refresh_count = 8'd0;
            full_period   = 8'd0;
            bytes_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_byte(i_m_tdata, i_m_tuser[0], i_m_tlast);
            end
            if (i_cfg_we) begin
                full_period = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_item(i_s_tdata);
            end
        end
        o_pending <= bytes_due.size();
        o_errors  <= err_count;
    end

endmodule

>>> sim/char_lcd_shadow_refresh_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_shadow_refresh_tb
// Drives put char, goto, fill, home, refresh and spare-opcode items into the display
// refresh block under several refresh periods, with random gaps on the input
// and random stalls on the output, and lets the checker judge every byte.
// ----------------------------------------------------------------------------
module char_lcd_shadow_refresh_tb;

    localparam int         ROWS           = clsr_pkg::ROWS_DEFAULT;
    localparam int         COLS           = clsr_pkg::COLS_DEFAULT;
    localparam logic [2:0] OP_SPARE_LO    = 3'd5;
    localparam logic [2:0] OP_SPARE_HI    = 3'd7;
    localparam int         SETTLE_CYCLES  = 200;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic [23:0] s_tdata     = 24'd0;
    logic        m_tready    = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'd0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    int   fail_count;
    int   bytes_outstanding;
    logic gaps_enabled = 1'b1;
    int   stall_left   = 0;
    int   quiet_cycles = 0;

    char_lcd_shadow_refresh dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    lcd_refresh_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tlast   (m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (fail_count),
        .o_pending   (bytes_outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (gaps_enabled && $urandom_range(0, 9) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [2:0] opc, input logic [7:0] ch,
                             input logic [5:0] col, input logic [1:0] row);
        if (gaps_enabled && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, row, col, ch, opc};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (bytes_outstanding != 0);
        // A refresh with no changed cells sends nothing but still walks the buffer.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [7:0] period);
        drain_and_settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= period;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random_item();
        int         pick;
        logic [7:0] ch;
        logic [5:0] col;
        logic [1:0] row;
        pick = $urandom_range(0, 99);
        ch   = 8'($urandom_range(0, 255));
        col  = 6'($urandom_range(0, 63));
        row  = 2'($urandom_range(0, 3));
        if (pick < 45) begin
            if ($urandom_range(0, 5) == 0) begin
                ch = clsr_pkg::CH_NEWLINE;
            end else if ($urandom_range(0, 5) == 0) begin
                ch = clsr_pkg::CH_TAB;
            end
            send_item(clsr_pkg::OP_PUT, ch, col, row);
        end else if (pick < 60) begin
            send_item(clsr_pkg::OP_REFRESH, ch, col, row);
        end else if (pick < 75) begin
            if ($urandom_range(0, 3) != 0) begin
                col = 6'($urandom_range(0, COLS - 1));
                row = 2'($urandom_range(0, ROWS - 1));
            end
            send_item(clsr_pkg::OP_GOTO, ch, col, row);
        end else if (pick < 80) begin
            send_item(clsr_pkg::OP_FILL, ch, col, row);
        end else if (pick < 92) begin
            send_item(clsr_pkg::OP_HOME, ch, col, row);
        end else if (pick < 96) begin
            send_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), ch, col, row);
        end else begin
            send_item(clsr_pkg::OP_REFRESH, ch, col, row);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every refresh is a full update while the period is zero.
        send_item(clsr_pkg::OP_REFRESH, 8'h00, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_PUT, 8'h00, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_PUT, 8'hFF, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_PUT, clsr_pkg::CH_TAB, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_PUT, clsr_pkg::CH_NEWLINE, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_GOTO, 8'h00, 6'(COLS - 1), 2'(ROWS - 1));
        send_item(clsr_pkg::OP_PUT, 8'h7E, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_PUT, 8'h55, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_GOTO, 8'h00, 6'd63, 2'd3);
        send_item(clsr_pkg::OP_GOTO, 8'h00, 6'(COLS), 2'd0);
        send_item(clsr_pkg::OP_GOTO, 8'h00, 6'd0, 2'(ROWS));
        send_item(clsr_pkg::OP_HOME, 8'h00, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_GOTO, 8'h00, 6'd5, 2'(ROWS - 1));
        send_item(clsr_pkg::OP_PUT, clsr_pkg::CH_NEWLINE, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_PUT, 8'h44, 6'd0, 2'd0);
        send_item(OP_SPARE_HI, 8'hFF, 6'd63, 2'd3);
        send_item(clsr_pkg::OP_FILL, 8'hFF, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_REFRESH, 8'h00, 6'd0, 2'd0);

        // Full, unchanged, one changed cell, then full again.
        write_period(8'd3);
        send_item(clsr_pkg::OP_REFRESH, 8'h00, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_REFRESH, 8'h00, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_HOME, 8'h00, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_PUT, 8'h5A, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_REFRESH, 8'h00, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_FILL, 8'h00, 6'd0, 2'd0);
        send_item(clsr_pkg::OP_REFRESH, 8'h00, 6'd0, 2'd0);

        write_period(8'd255);
        repeat (21) send_random_item();
        write_period(8'd1);
        repeat (21) send_random_item();
        write_period(8'($urandom_range(2, 8)));
        repeat (21) send_random_item();
        write_period(8'd0);
        gaps_enabled <= 1'b0;
        repeat (22) send_random_item();

        drain_and_settle();
        if (fail_count == 0 && bytes_outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/clsr_pkg.sv
hw/rtl/clsr_cell_store.sv
hw/rtl/char_lcd_shadow_refresh.sv
hw/rtl/clsr_checker.sv
sim/lcd_refresh_checker.sv
sim/char_lcd_shadow_refresh_tb.sv
